// ----- sv/alternating_bit_sender_assert.svh -----
// assertion macros shared by abs_front and abs_queue
`ifndef ALTERNATING_BIT_SENDER_ASSERT_SVH
`define ALTERNATING_BIT_SENDER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ABS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("abs assertion failed");

// next-cycle implication, checked outside reset
`define ABS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("abs assertion failed");

`endif

// ----- sv/abs_pkg.sv -----
// ----------------------------------------------------------------------------
// abs_pkg
// Types and constants of the alternating-bit sender.
// ----------------------------------------------------------------------------
`default_nettype none

package abs_pkg;

    localparam int PAYLOAD_SIZE = 5;
    localparam int PAY_W        = 40;
    localparam int FILL_W       = $clog2(PAYLOAD_SIZE + 1);
    localparam int LEN_W        = 3;
    localparam int TICK_W       = 16;
    localparam int QDEPTH       = 4;
    localparam int QPTR_W       = $clog2(QDEPTH);
    localparam int QCNT_W       = $clog2(QDEPTH + 1);

    localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(1000);

    typedef enum logic [1:0] {
        MODE_BYTE = 2'd0,
        MODE_ACK  = 2'd1,
        MODE_TICK = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_SENT      = 3'd1,
        EV_RESENT    = 3'd2,
        EV_REFUSED   = 3'd3,
        EV_ACKED     = 3'd4,
        EV_DELIVERED = 3'd5,
        EV_IGNORED   = 3'd6
    } t_event;

    typedef enum logic {
        ST_FILL = 1'b0,
        ST_WAIT = 1'b1
    } t_state;

    typedef struct packed {
        t_event             ev;
        logic               seq;
        logic               last;
        logic [LEN_W-1:0]   len;
        logic [PAY_W-1:0]   payload;
    } t_cmd;

endpackage

`default_nettype wire

// ----- sv/abs_front.sv -----
// ----------------------------------------------------------------------------
// abs_front
// Accepts bytes, acks and ticks, keeps the protocol state and classifies
// each item into one command for the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alternating_bit_sender_assert.svh"

module abs_front (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_accept,
    input  wire logic [1:0]                 i_mode,
    input  wire logic [7:0]                 i_data_byte,
    input  wire logic                       i_end_of_message,
    input  wire logic [7:0]                 i_ack_number,
    input  wire logic [7:0]                 i_ack_corrupt,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [abs_pkg::TICK_W-1:0] i_cfg_wr_data,
    output abs_pkg::t_cmd                   o_cmd
);
    import abs_pkg::*;

    t_state              r_state, n_state;
    logic                r_seq, n_seq;
    logic                r_last, n_last;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic [7:0]          r_bytes [PAYLOAD_SIZE];
    logic [7:0]          n_bytes [PAYLOAD_SIZE];
    logic [TICK_W-1:0]   r_wait, n_wait;
    logic [TICK_W-1:0]   r_timeout;
    logic [TICK_W-1:0]   limit;
    logic [TICK_W-1:0]   wait_inc;
    logic [FILL_W-1:0]   fill_inc;
    logic                ack_good;
    logic                send_now;
    logic                timed_out;
    logic [PAY_W-1:0]    pay;

    assign limit     = (r_timeout == '0) ? TICK_W'(1) : r_timeout;
    assign wait_inc  = r_wait + TICK_W'(1);
    assign timed_out = (wait_inc >= limit);
    assign fill_inc  = r_fill + FILL_W'(1);
    assign ack_good  = (i_ack_corrupt == 8'd0) && (i_ack_number == {7'd0, r_seq});
    assign send_now  = (fill_inc >= FILL_W'(PAYLOAD_SIZE)) || i_end_of_message;

    // next state
    always_comb begin
        n_state = r_state;
        if (i_accept) begin
            unique case (r_state)
                ST_FILL: begin
                    if (i_mode == MODE_BYTE && send_now) begin
                        n_state = ST_WAIT;
                    end
                end
                ST_WAIT: begin
                    if (i_mode == MODE_ACK && ack_good) begin
                        n_state = ST_FILL;
                    end
                end
                default: n_state = ST_FILL;
            endcase
        end
    end

    // datapath and command
    always_comb begin
        n_seq   = r_seq;
        n_last  = r_last;
        n_fill  = r_fill;
        n_bytes = r_bytes;
        n_wait  = r_wait;
        o_cmd.ev = EV_NONE;
        unique case (i_mode)
            MODE_BYTE: begin
                if (r_state == ST_WAIT) begin
                    o_cmd.ev = EV_REFUSED;
                end else begin
                    for (int i = 0; i < PAYLOAD_SIZE; i++) begin
                        if (r_fill == FILL_W'(i)) begin
                            n_bytes[i] = i_data_byte;
                        end
                    end
                    n_fill = fill_inc;
                    if (send_now) begin
                        n_last   = i_end_of_message;
                        n_wait   = '0;
                        o_cmd.ev = EV_SENT;
                    end
                end
            end
            MODE_ACK: begin
                if (r_state == ST_FILL) begin
                    o_cmd.ev = EV_IGNORED;
                end else if (!ack_good) begin
                    n_wait   = '0;
                    o_cmd.ev = EV_RESENT;
                end else begin
                    n_wait = '0;
                    n_fill = '0;
                    for (int i = 0; i < PAYLOAD_SIZE; i++) begin
                        n_bytes[i] = 8'd0;
                    end
                    if (r_last) begin
                        n_seq    = 1'b0;
                        n_last   = 1'b0;
                        o_cmd.ev = EV_DELIVERED;
                    end else begin
                        n_seq    = ~r_seq;
                        o_cmd.ev = EV_ACKED;
                    end
                end
            end
            MODE_TICK: begin
                if (r_state == ST_WAIT) begin
                    if (timed_out) begin
                        n_wait   = '0;
                        o_cmd.ev = EV_RESENT;
                    end else begin
                        n_wait = wait_inc;
                    end
                end
            end
            default: o_cmd.ev = EV_NONE;
        endcase

        pay = '0;
        for (int i = 0; i < PAYLOAD_SIZE; i++) begin
            if (8 * i < PAY_W) begin
                pay[8*i +: 8] = n_bytes[i];
            end
        end
        o_cmd.seq     = r_seq;
        o_cmd.last    = n_last;
        o_cmd.len     = LEN_W'(n_fill);
        o_cmd.payload = pay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_FILL;
            r_seq     <= 1'b0;
            r_last    <= 1'b0;
            r_fill    <= '0;
            r_wait    <= '0;
            r_timeout <= TIMEOUT_RESET;
            for (int i = 0; i < PAYLOAD_SIZE; i++) begin
                r_bytes[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_state <= n_state;
                r_seq   <= n_seq;
                r_last  <= n_last;
                r_fill  <= n_fill;
                r_wait  <= n_wait;
                r_bytes <= n_bytes;
            end
        end
    end

    `ABS_ASSERT_IMP(a_fill_room, i_clk, i_rst_n, r_state == ST_FILL, r_fill < FILL_W'(PAYLOAD_SIZE))
    `ABS_ASSERT_NEXT(a_refuse_hold, i_clk, i_rst_n, i_accept && o_cmd.ev == EV_REFUSED, $stable(r_fill) && $stable(r_seq) && r_state == ST_WAIT)
    `ABS_ASSERT_NEXT(a_sent_waits, i_clk, i_rst_n, i_accept && o_cmd.ev == EV_SENT, r_state == ST_WAIT && r_wait == '0)

endmodule

`default_nettype wire

// ----- sv/abs_queue.sv -----
// ----------------------------------------------------------------------------
// abs_queue
// Short register queue of commands between the front and the output side.
// ----------------------------------------------------------------------------
`default_nettype none

`include "alternating_bit_sender_assert.svh"

module abs_queue (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire abs_pkg::t_cmd i_cmd,
    input  wire logic    i_pop,
    output logic         o_full,
    output logic         o_empty,
    output abs_pkg::t_cmd o_cmd
);
    import abs_pkg::*;

    t_cmd                r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == QCNT_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `ABS_ASSERT_IMP(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= QCNT_W'(QDEPTH))
    `ABS_ASSERT_NEXT(a_count_grows, i_clk, i_rst_n, do_push && !do_pop, r_count == $past(r_count) + QCNT_W'(1))

endmodule

`default_nettype wire

// ----- sv/abs_back.sv -----
// ----------------------------------------------------------------------------
// abs_back
// Turns the oldest command into result fields; segment fields are shown
// only for sent and resent events.
// ----------------------------------------------------------------------------
`default_nettype none

module abs_back (
    input  wire abs_pkg::t_cmd               i_cmd,
    output logic [2:0]                       o_event_res,
    output logic                             o_seq_bit,
    output logic                             o_last_segment,
    output logic [abs_pkg::LEN_W-1:0]        o_payload_length,
    output logic [abs_pkg::PAY_W-1:0]        o_payload
);
    import abs_pkg::*;

    always_comb begin
        o_event_res = i_cmd.ev;
        unique case (i_cmd.ev) inside
            EV_SENT, EV_RESENT: begin
                o_seq_bit        = i_cmd.seq;
                o_last_segment   = i_cmd.last;
                o_payload_length = i_cmd.len;
                o_payload        = i_cmd.payload;
            end
            default: begin
                o_seq_bit        = 1'b0;
                o_last_segment   = 1'b0;
                o_payload_length = '0;
                o_payload        = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- sv/alternating_bit_sender.sv -----
// ----------------------------------------------------------------------------
// alternating_bit_sender: stop-and-wait sender, one result per item
// path: the front classifies combinationally and the queue registers each result at its transfer
// throughput: one item per cycle, held back only when the 4-entry queue fills
// reset: state cleared, sequence bit zero, timeout back to 1000 ticks
// ----------------------------------------------------------------------------
`default_nettype none

module alternating_bit_sender (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_push,
    output logic                            o_full,
    input  wire logic [1:0]                 i_mode,
    input  wire logic [7:0]                 i_data_byte,
    input  wire logic                       i_end_of_message,
    input  wire logic [7:0]                 i_ack_number,
    input  wire logic [7:0]                 i_ack_corrupt,
    input  wire logic                       i_cfg_wr_en,
    input  wire logic [abs_pkg::TICK_W-1:0] i_cfg_wr_data,
    output logic                            o_empty,
    input  wire logic                       i_pop,
    output logic [2:0]                      o_event_res,
    output logic                            o_seq_bit,
    output logic                            o_last_segment,
    output logic [abs_pkg::LEN_W-1:0]       o_payload_length,
    output logic [abs_pkg::PAY_W-1:0]       o_payload
);
    import abs_pkg::*;

    logic accept;
    t_cmd front_cmd;
    t_cmd head_cmd;

    assign accept = i_push && !o_full;

    abs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_mode           (i_mode),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_ack_number     (i_ack_number),
        .i_ack_corrupt    (i_ack_corrupt),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_cmd            (front_cmd)
    );

    abs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .i_pop   (i_pop),
        .o_full  (o_full),
        .o_empty (o_empty),
        .o_cmd   (head_cmd)
    );

    abs_back u_back (
        .i_cmd            (head_cmd),
        .o_event_res      (o_event_res),
        .o_seq_bit        (o_seq_bit),
        .o_last_segment   (o_last_segment),
        .o_payload_length (o_payload_length),
        .o_payload        (o_payload)
    );

endmodule

`default_nettype wire

// ----- tb/alternating_bit_sender_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alternating_bit_sender_tb
// Drives message bytes, acks and timer ticks into the stop-and-wait sender
// under several timeout settings and idle patterns, and checks every result
// transfer against a cycle-free model of the sender's segment state.
// ----------------------------------------------------------------------------

module alternating_bit_sender_tb;

    import abs_pkg::*;

    localparam logic [1:0] MODE_SPARE  = 2'd3;
    localparam int         HOLD_CYCLES = 150;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_ITEMS = 142;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] data_byte;
        logic       eom;
        logic [7:0] ack_number;
        logic [7:0] ack_corrupt;
    } t_item;

    class segment_scoreboard;
        logic [TICK_W-1:0] timeout_ticks;
        logic              seq_bit;
        logic              awaiting_ack;
        logic              closes_msg;
        logic [7:0]        seg_bytes [PAYLOAD_SIZE];
        logic [2:0]        fill_count;
        logic [TICK_W-1:0] wait_ticks;
        t_cmd              pending_reports [$];
        int                errors;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            seq_bit       = 1'b0;
            awaiting_ack  = 1'b0;
            closes_msg    = 1'b0;
            fill_count    = '0;
            wait_ticks    = '0;
            errors        = 0;
            foreach (seg_bytes[i]) seg_bytes[i] = 8'h00;
        endfunction

        function void set_timeout(logic [TICK_W-1:0] value);
            timeout_ticks = value;
        endfunction

        function t_cmd segment_report(t_event ev);
            t_cmd r;
            r         = '0;
            r.ev      = ev;
            r.seq     = seq_bit;
            r.last    = closes_msg;
            r.len     = fill_count;
            for (int i = 0; i < PAYLOAD_SIZE; i++) r.payload[8*i +: 8] = seg_bytes[i];
            wait_ticks = '0;
            return r;
        endfunction

        function t_cmd advance_sender(t_item it);
            t_cmd              r;
            logic [TICK_W-1:0] limit;
            r    = '0;
            r.ev = EV_NONE;
            case (it.mode)
                MODE_BYTE: begin
                    if (awaiting_ack) begin
                        r.ev = EV_REFUSED;
                    end else begin
                        if (fill_count < PAYLOAD_SIZE) seg_bytes[fill_count] = it.data_byte;
                        fill_count = fill_count + 3'd1;
                        if (fill_count >= PAYLOAD_SIZE || it.eom) begin
                            closes_msg   = it.eom;
                            awaiting_ack = 1'b1;
                            r            = segment_report(EV_SENT);
                        end
                    end
                end
                MODE_ACK: begin
                    if (!awaiting_ack) begin
                        r.ev = EV_IGNORED;
                    end else if (it.ack_corrupt != 8'h00 || it.ack_number != {7'd0, seq_bit}) begin
                        r = segment_report(EV_RESENT);
                    end else begin
                        awaiting_ack = 1'b0;
                        wait_ticks   = '0;
                        fill_count   = '0;
                        foreach (seg_bytes[i]) seg_bytes[i] = 8'h00;
                        if (closes_msg) begin
                            seq_bit    = 1'b0;
                            closes_msg = 1'b0;
                            r.ev       = EV_DELIVERED;
                        end else begin
                            seq_bit = ~seq_bit;
                            r.ev    = EV_ACKED;
                        end
                    end
                end
                MODE_TICK: begin
                    if (awaiting_ack) begin
                        limit      = (timeout_ticks == '0) ? TICK_W'(1) : timeout_ticks;
                        wait_ticks = wait_ticks + TICK_W'(1);
                        if (wait_ticks >= limit) r = segment_report(EV_RESENT);
                    end
                end
                default: begin
                end
            endcase
            return r;
        endfunction

        function void note_transfer(t_item it);
            pending_reports.insert(pending_reports.size(), advance_sender(it));
        endfunction

        function void check_report(t_cmd got);
            t_cmd exp;
            if (pending_reports.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                errors++;
                return;
            end
            exp = pending_reports.pop_front();
            if (got.ev !== exp.ev) begin
                $display("%0t: event expected %0d actual %0d", $time, exp.ev, got.ev);
                errors++;
            end
            if (got.seq !== exp.seq) begin
                $display("%0t: seq_bit expected %0d actual %0d", $time, exp.seq, got.seq);
                errors++;
            end
            if (got.last !== exp.last) begin
                $display("%0t: last_segment expected %0d actual %0d", $time, exp.last, got.last);
                errors++;
            end
            if (got.len !== exp.len) begin
                $display("%0t: payload_length expected %0d actual %0d", $time, exp.len, got.len);
                errors++;
            end
            if (got.payload !== exp.payload) begin
                $display("%0t: payload expected %h actual %h", $time, exp.payload, got.payload);
                errors++;
            end
        endfunction
    endclass

    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              i_push           = 1'b0;
    logic [1:0]        i_mode           = '0;
    logic [7:0]        i_data_byte      = '0;
    logic              i_end_of_message = 1'b0;
    logic [7:0]        i_ack_number     = '0;
    logic [7:0]        i_ack_corrupt    = '0;
    logic              i_cfg_wr_en      = 1'b0;
    logic [TICK_W-1:0] i_cfg_wr_data    = '0;
    logic              i_pop            = 1'b0;
    logic              o_full;
    logic              o_empty;
    logic [2:0]        o_event_res;
    logic              o_seq_bit;
    logic              o_last_segment;
    logic [LEN_W-1:0]  o_payload_length;
    logic [PAY_W-1:0]  o_payload;

    segment_scoreboard scoreboard = new();
    segment_scoreboard lookahead  = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    bit hold_request  = 1'b0;

    alternating_bit_sender dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (i_push),
        .o_full           (o_full),
        .i_mode           (i_mode),
        .i_data_byte      (i_data_byte),
        .i_end_of_message (i_end_of_message),
        .i_ack_number     (i_ack_number),
        .i_ack_corrupt    (i_ack_corrupt),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .o_empty          (o_empty),
        .i_pop            (i_pop),
        .o_event_res      (o_event_res),
        .o_seq_bit        (o_seq_bit),
        .o_last_segment   (o_last_segment),
        .o_payload_length (o_payload_length),
        .o_payload        (o_payload)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("alternating_bit_sender_tb NOT OK");
        $finish;
    end

    // result side: check each transfer, then choose pop for the next cycle
    initial begin
        t_cmd got;
        int   hold_left;
        hold_left = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (i_pop && !o_empty) begin
                got.ev      = t_event'(o_event_res);
                got.seq     = o_seq_bit;
                got.last    = o_last_segment;
                got.len     = o_payload_length;
                got.payload = o_payload;
                scoreboard.check_report(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
                i_pop <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
                i_pop <= 1'b0;
            end else begin
                i_pop <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    function automatic t_item pick(logic [1:0] mode, logic [7:0] data, logic eom,
                                   logic [7:0] num, logic [7:0] bad);
        t_item it;
        it.mode        = mode;
        it.data_byte   = data;
        it.eom         = eom;
        it.ack_number  = num;
        it.ack_corrupt = bad;
        return it;
    endfunction

    function automatic t_item random_item();
        t_item it;
        it = pick(2'($urandom_range(3)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                  8'($urandom_range(255)), 8'($urandom_range(255)));
        return it;
    endfunction

    task automatic send_item(t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push           <= 1'b1;
        i_mode           <= it.mode;
        i_data_byte      <= it.data_byte;
        i_end_of_message <= it.eom;
        i_ack_number     <= it.ack_number;
        i_ack_corrupt    <= it.ack_corrupt;
        void'(lookahead.advance_sender(it));
        do @(posedge i_clk); while (o_full);
        scoreboard.note_transfer(it);
    endtask

    task automatic wait_quiet();
        i_push <= 1'b0;
        while (scoreboard.pending_reports.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [TICK_W-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        scoreboard.set_timeout(value);
        lookahead.set_timeout(value);
    endtask

    // disturb the wait for an ack, then close it with a clean ack
    task automatic settle_segment(inout int n);
        t_item it;
        int    k;
        repeat ($urandom_range(0, 4)) begin
            it = random_item();
            case ($urandom_range(3))
                0: begin
                    it.mode = MODE_TICK;
                    for (k = $urandom_range(1, 6); k > 0; k--) begin
                        send_item(it);
                        n++;
                    end
                end
                1: begin
                    it.mode        = MODE_ACK;
                    it.ack_corrupt = 8'($urandom_range(1, 255));
                    send_item(it);
                    n++;
                end
                2: begin
                    it.mode        = MODE_ACK;
                    it.ack_number  = {7'd0, lookahead.seq_bit} ^ 8'($urandom_range(1, 255));
                    send_item(it);
                    n++;
                end
                default: begin
                    it.mode = MODE_BYTE;
                    send_item(it);
                    n++;
                end
            endcase
        end
        it             = random_item();
        it.mode        = MODE_ACK;
        it.ack_number  = {7'd0, lookahead.seq_bit};
        it.ack_corrupt = 8'h00;
        send_item(it);
        n++;
    endtask

    task automatic play_message(inout int n);
        t_item it;
        int    len;
        len = ($urandom_range(9) == 0) ? $urandom_range(11, 16) : $urandom_range(1, 10);
        if (lookahead.awaiting_ack) settle_segment(n);
        for (int k = 0; k < len; k++) begin
            it      = random_item();
            it.mode = MODE_BYTE;
            it.eom  = (k == len - 1);
            send_item(it);
            n++;
            if (lookahead.awaiting_ack) settle_segment(n);
        end
    endtask

    task automatic run_random(int count);
        t_item it;
        int    n;
        n = 0;
        while (n < count) begin
            if ($urandom_range(99) < 80) begin
                play_message(n);
            end else begin
                it = random_item();
                if ($urandom_range(1)) it.ack_number = 8'($urandom_range(1));
                if ($urandom_range(1)) it.ack_corrupt = 8'h00;
                send_item(it);
                n++;
            end
        end
    endtask

    initial begin
        logic [TICK_W-1:0] timeouts [6];
        timeouts = '{16'd0, 16'd1, 16'd3, 16'hFFFF, 16'd2, 16'd6};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 9;
        recv_idle_pct = 63;

        // directed part under the reset timeout
        send_item(pick(MODE_TICK,  8'h00, 1'b0, 8'h00, 8'h00));
        send_item(pick(MODE_ACK,   8'h00, 1'b0, 8'hFF, 8'hFF));
        send_item(pick(MODE_SPARE, 8'hFF, 1'b1, 8'hFF, 8'hFF));
        send_item(pick(MODE_BYTE,  8'h00, 1'b0, 8'h00, 8'h00));
        send_item(pick(MODE_BYTE,  8'hFF, 1'b0, 8'hFF, 8'hFF));
        send_item(pick(MODE_BYTE,  8'hA5, 1'b0, 8'h00, 8'h00));
        send_item(pick(MODE_BYTE,  8'h5A, 1'b0, 8'h00, 8'h00));
        send_item(pick(MODE_BYTE,  8'h01, 1'b0, 8'h00, 8'h00));
        send_item(pick(MODE_BYTE,  8'hFF, 1'b1, 8'h00, 8'h00));
        send_item(pick(MODE_TICK,  8'h00, 1'b0, 8'h00, 8'h00));
        send_item(pick(MODE_ACK,   8'h00, 1'b0, 8'h00, 8'h80));
        send_item(pick(MODE_ACK,   8'h00, 1'b0, 8'h01, 8'h00));
        send_item(pick(MODE_ACK,   8'h00, 1'b0, 8'h00, 8'h00));
        send_item(pick(MODE_BYTE,  8'h3C, 1'b1, 8'h00, 8'h00));
        send_item(pick(MODE_ACK,   8'h00, 1'b0, 8'h00, 8'h00));
        send_item(pick(MODE_ACK,   8'h00, 1'b0, 8'h01, 8'h01));
        send_item(pick(MODE_ACK,   8'h00, 1'b0, 8'h01, 8'h00));
        send_item(pick(MODE_BYTE,  8'h77, 1'b0, 8'h00, 8'h00));
        send_item(pick(MODE_BYTE,  8'h88, 1'b1, 8'h00, 8'h00));
        send_item(pick(MODE_ACK,   8'h00, 1'b0, 8'h00, 8'h00));
        wait_quiet();

        for (int p = 0; p < 6; p++) begin
            write_timeout(timeouts[p]);
            if (p < 2) begin
                send_idle_pct = 9;
                recv_idle_pct = 63;
            end else if (p < 4) begin
                send_idle_pct = 63;
                recv_idle_pct = 9;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // long receiver stall while the sender keeps offering transfers
            if (p == 0 || p == 4) hold_request = 1'b1;
            run_random(PHASE_ITEMS);
            wait_quiet();
        end

        repeat (8) @(posedge i_clk);
        if (scoreboard.pending_reports.size() != 0)
            $display("%0t: %0d results never arrived", $time,
                     scoreboard.pending_reports.size());
        if (scoreboard.errors == 0 && scoreboard.pending_reports.size() == 0) begin
            $display("alternating_bit_sender_tb OK");
        end else begin
            $display("alternating_bit_sender_tb NOT OK");
        end
        $finish;
    end

endmodule
